// File: rtl/core/baro_sensor_compensation_core_defines.svh
// assertion macros for the barometric compensation core
// used by the checker module only
`ifndef BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define BSC_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define BSC_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/core/bsc_pkg.sv
// package for the barometric compensation core
// types, constants and a saturating add helper; no dependencies
package bsc_pkg;
    localparam int FracBitsDefault = 16;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 64;
    localparam logic [CfgIdxW-1:0] CFG_TEMP = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLO = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PHI = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [23:0] raw_sample;
        logic        report_raw;
    } bsc_in_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [47:0] value;
    } bsc_out_t;

    // datapath operand sources
    typedef enum logic [3:0] {
        SRC_ACC, SRC_D, SRC_T, SRC_T2, SRC_T3, SRC_P, SRC_PP, SRC_IN2, SRC_IN3,
        SRC_CAL, SRC_PP11, SRC_ONE
    } src_t;

    // one micro-op: mul a*b >> sh, then optional accumulate, then destination
    typedef enum logic [3:0] {
        DST_NONE, DST_D, DST_T2, DST_T3, DST_PP, DST_IN2, DST_IN3, DST_PP11, DST_ACC,
        DST_ACC_ADD, DST_LT
    } dst_t;

    typedef struct packed {
        logic       valid;
        src_t       src_a;
        src_t       src_b;
        logic [6:0] shift;
        logic       acc_clear;
        dst_t       dst;
    } bsc_cmd_t;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic signed [63:0] sadd64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) sadd64 = s[64] ? S64_MIN : S64_MAX;
        else sadd64 = s[63:0];
    endfunction
endpackage

// File: rtl/core/bsc_datapath.sv
// datapath: operand registers, one shared 64x64 multiply-shift unit, accumulator
// depends on bsc_pkg
module bsc_datapath import bsc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  bsc_cmd_t           cmd,
    input  logic               load,
    input  logic        [23:0] raw_in,
    input  logic signed [63:0] cal_val,
    output logic               mul_done,
    output logic signed [63:0] acc_q,
    output logic signed [31:0] last_temp
);
    // the multiply is split: operand capture, four 32x32 partial products,
    // partial sum, floor and saturate, write-back
    logic signed [63:0] d_reg, t2_reg, t3_reg, pp_reg, in2_reg, in3_reg, pp11_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] lt_reg;
    logic        [23:0] p_reg;
    logic signed [63:0] a_sel, b_sel;
    logic [63:0] ua_reg, ub_reg;
    logic        neg_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [127:0] prod, prod_reg;
    logic [127:0] q;
    logic         rem;
    logic signed [63:0] res, res_reg, wb_sum;
    bsc_cmd_t    hold_reg;

    function automatic logic signed [63:0] pick(src_t s, logic signed [63:0] acc,
        logic signed [63:0] d, logic signed [31:0] t, logic signed [63:0] t2,
        logic signed [63:0] t3, logic [23:0] p, logic signed [63:0] pp,
        logic signed [63:0] in2, logic signed [63:0] in3, logic signed [63:0] cal,
        logic signed [63:0] pp11);
        unique case (s)
            SRC_ACC:  pick = acc;
            SRC_D:    pick = d;
            SRC_T:    pick = 64'(t);
            SRC_T2:   pick = t2;
            SRC_T3:   pick = t3;
            SRC_P:    pick = {40'd0, p};
            SRC_PP:   pick = pp;
            SRC_IN2:  pick = in2;
            SRC_IN3:  pick = in3;
            SRC_CAL:  pick = cal;
            SRC_PP11: pick = pp11;
            SRC_ONE:  pick = 64'sd1;
            default:  pick = '0;
        endcase
    endfunction

    assign a_sel = pick(cmd.src_a, acc_reg, d_reg, lt_reg, t2_reg, t3_reg, p_reg,
                        pp_reg, in2_reg, in3_reg, cal_val, pp11_reg);
    assign b_sel = pick(cmd.src_b, acc_reg, d_reg, lt_reg, t2_reg, t3_reg, p_reg,
                        pp_reg, in2_reg, in3_reg, cal_val, pp11_reg);

    assign prod = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
                + {p11_reg, 64'd0};

    always_comb begin
        q = prod_reg >> hold_reg.shift;
        rem = (prod_reg & ~({128{1'b1}} << hold_reg.shift)) != '0;
        if (neg_reg) begin
            q = q + {127'd0, rem};
            if (q > {64'd0, 64'h8000_0000_0000_0000}) res = S64_MIN;
            else res = 64'(-q[63:0]);
        end else begin
            if (q > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF}) res = S64_MAX;
            else res = q[63:0];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            3'd0:    if (cmd.valid) phase_next = 3'd1;
            3'd1:    phase_next = 3'd2;
            3'd2:    phase_next = 3'd3;
            3'd3:    phase_next = 3'd4;
            default: phase_next = 3'd0;
        endcase
    end
    assign mul_done = (phase_reg == 3'd4);

    assign wb_sum = sadd64(acc_reg, res_reg);

    always_comb begin
        acc_next = acc_reg;
        if (load) acc_next = '0;
        else if (mul_done) begin
            if (hold_reg.acc_clear || hold_reg.dst == DST_ACC) acc_next = res_reg;
            else if (hold_reg.dst == DST_ACC_ADD) acc_next = wb_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 3'd0;
            lt_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            if (mul_done && hold_reg.dst == DST_LT) begin
                if (wb_sum > 64'sd2147483647) lt_reg <= 32'h7FFF_FFFF;
                else if (wb_sum < -64'sd2147483648) lt_reg <= 32'h8000_0000;
                else lt_reg <= 32'(wb_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (load) p_reg <= raw_in;
        if (cmd.valid && phase_reg == 3'd0) begin
            hold_reg <= cmd;
            neg_reg  <= a_sel[63] ^ b_sel[63];
            ua_reg   <= a_sel[63] ? 64'(-a_sel) : a_sel;
            ub_reg   <= b_sel[63] ? 64'(-b_sel) : b_sel;
        end
        if (phase_reg == 3'd1) begin
            p00_reg <= 64'(ua_reg[31:0]) * 64'(ub_reg[31:0]);
            p01_reg <= 64'(ua_reg[31:0]) * 64'(ub_reg[63:32]);
            p10_reg <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            p11_reg <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);
        end
        if (phase_reg == 3'd2) prod_reg <= prod;
        if (phase_reg == 3'd3) res_reg <= res;
        if (mul_done) begin
            unique case (hold_reg.dst)
                DST_D:    d_reg <= res_reg;
                DST_T2:   t2_reg <= res_reg;
                DST_T3:   t3_reg <= res_reg;
                DST_PP:   pp_reg <= res_reg;
                DST_IN2:  in2_reg <= wb_sum;
                DST_IN3:  in3_reg <= wb_sum;
                DST_PP11: pp11_reg <= res_reg;
                default:  ;
            endcase
        end
    end

    assign acc_q     = acc_reg;
    assign last_temp = lt_reg;
endmodule

// File: rtl/core/bsc_control.sv
// controller: sequences micro-ops through the datapath for one item
// depends on bsc_pkg
module bsc_control import bsc_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bsc_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bsc_out_t           m_data,
    input  logic [39:0]        temp_cal,
    input  logic [63:0]        plo,
    input  logic [63:0]        phi,
    input  logic               mul_done,
    input  logic signed [63:0] acc_q,
    input  logic signed [31:0] last_temp,
    output bsc_cmd_t           cmd,
    output logic               load,
    output logic signed [63:0] cal_val
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_FIN = 4'b0100, ST_OUT = 4'b1000
    } state_t;
    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] last_step;
    bsc_in_t    item_reg;
    bsc_out_t   out_reg;
    logic       out_valid_reg;
    logic signed [63:0] t1, t2c, t3c, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [63:0] d_raw;

    assign t1  = {48'd0, temp_cal[15:0]};
    assign t2c = {48'd0, temp_cal[31:16]};
    assign t3c = 64'(signed'(temp_cal[39:32]));
    assign p1  = 64'(signed'(plo[15:0]));
    assign p2  = 64'(signed'(plo[31:16]));
    assign p3  = 64'(signed'(plo[39:32]));
    assign p4  = 64'(signed'(plo[47:40]));
    assign p5  = {48'd0, plo[63:48]};
    assign p6  = {48'd0, phi[15:0]};
    assign p7  = 64'(signed'(phi[23:16]));
    assign p8  = 64'(signed'(phi[31:24]));
    assign p9  = 64'(signed'(phi[47:32]));
    assign p10 = 64'(signed'(phi[55:48]));
    assign p11 = 64'(signed'(phi[63:56]));
    assign d_raw = {40'd0, item_reg.raw_sample} - (t1 <<< 8);

    function automatic bsc_cmd_t op(src_t a, src_t b, int sh, logic clr, dst_t d);
        op.valid = 1'b1; op.src_a = a; op.src_b = b; op.shift = 7'(sh);
        op.acc_clear = clr; op.dst = d;
    endfunction

    // micro-program; calibration operand chosen per step
    always_comb begin
        cmd = '0;
        cal_val = '0;
        last_step = item_reg.kind ? 5'd17 : 5'd4;
        if (state_reg == ST_RUN) begin
            if (!item_reg.kind) begin
                unique case (step_reg)
                    5'd0: begin cmd = op(SRC_CAL, SRC_CAL, 0, 1'b0, DST_D);
                        cal_val = d_raw; end
                    5'd1: begin cmd = op(SRC_D, SRC_CAL, 30 - FRAC_BITS, 1'b1, DST_NONE);
                        cal_val = t2c; end
                    5'd2: begin cmd = op(SRC_D, SRC_D, 0, 1'b0, DST_PP); end
                    default: begin cmd = op(SRC_PP, SRC_CAL, 48 - FRAC_BITS, 1'b0, DST_LT);
                        cal_val = t3c; end
                endcase
            end else begin
                unique case (step_reg)
                    5'd0: cmd = op(SRC_T, SRC_T, FRAC_BITS, 1'b0, DST_T2);
                    5'd1: cmd = op(SRC_T2, SRC_T, FRAC_BITS, 1'b0, DST_T3);
                    5'd2: begin cmd = op(SRC_CAL, SRC_CAL, 0, 1'b1, DST_NONE);
                        cal_val = (p1 - 64'sd16384) <<< (9 + FRAC_BITS); end
                    5'd3: begin cmd = op(SRC_CAL, SRC_T, 0, 1'b0, DST_ACC_ADD);
                        cal_val = p2 - 64'sd16384; end
                    5'd4: begin cmd = op(SRC_CAL, SRC_T2, 0, 1'b0, DST_ACC_ADD);
                        cal_val = p3 <<< 3; end
                    5'd5: begin cmd = op(SRC_CAL, SRC_T3, 8, 1'b0, DST_IN2);
                        cal_val = p4; end
                    5'd6: begin cmd = op(SRC_CAL, SRC_CAL, 0, 1'b1, DST_NONE);
                        cal_val = p9 <<< FRAC_BITS; end
                    5'd7: begin cmd = op(SRC_CAL, SRC_T, 0, 1'b0, DST_IN3);
                        cal_val = p10; end
                    5'd8: cmd = op(SRC_P, SRC_P, 0, 1'b0, DST_PP);
                    5'd9: begin cmd = op(SRC_P, SRC_CAL, 0, 1'b0, DST_PP11);
                        cal_val = p11; end
                    5'd10: cmd = op(SRC_PP, SRC_IN3, 48, 1'b1, DST_NONE);
                    5'd11: cmd = op(SRC_PP, SRC_PP11, 65 - FRAC_BITS, 1'b0, DST_ACC_ADD);
                    5'd12: cmd = op(SRC_P, SRC_IN2, 29, 1'b0, DST_ACC_ADD);
                    5'd13: begin cmd = op(SRC_CAL, SRC_CAL, 0, 1'b0, DST_ACC_ADD);
                        cal_val = p5 <<< (3 + FRAC_BITS); end
                    5'd14: begin cmd = op(SRC_CAL, SRC_T, 6, 1'b0, DST_ACC_ADD);
                        cal_val = p6; end
                    5'd15: begin cmd = op(SRC_CAL, SRC_T2, 8, 1'b0, DST_ACC_ADD);
                        cal_val = p7; end
                    5'd16: begin cmd = op(SRC_CAL, SRC_T3, 15, 1'b0, DST_ACC_ADD);
                        cal_val = p8; end
                    default: cmd = '0;
                endcase
            end
            // steps whose two operands are both the calibration value are multiplied by one
            if (cmd.valid && cmd.src_b == SRC_CAL && cmd.src_a == SRC_CAL) begin
                cmd.src_b = SRC_ONE;
                cmd.src_a = SRC_CAL;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                state_next = ST_RUN; step_next = '0; end
            ST_RUN: if (mul_done) begin
                if (step_reg == last_step - 5'd1) state_next = ST_FIN;
                else step_next = step_reg + 5'd1;
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_OUT && state_next == ST_IDLE) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) item_reg <= s_data;
        if (state_reg == ST_OUT && state_next == ST_IDLE) begin
            out_reg.result_kind <= item_reg.kind;
            if (item_reg.report_raw) out_reg.value <= {24'd0, item_reg.raw_sample};
            else if (!item_reg.kind) out_reg.value <= 48'(last_temp);
            else if (acc_q > 64'sh7FFF_FFFF_FFFF) out_reg.value <= 48'h7FFF_FFFF_FFFF;
            else if (acc_q < -64'sh8000_0000_0000) out_reg.value <= 48'h8000_0000_0000;
            else out_reg.value <= acc_q[47:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// File: rtl/core/baro_sensor_compensation_core.sv
// one item at a time; the next item can be accepted in the cycle after its result is registered
// each item runs 4 (temperature) or 17 (pressure) micro-ops through the shared
// multiply-shift unit; a result waits in the output register while the next
// item runs, and a second finished result stalls until the first is taken
// reset: synchronous active-low aresetn clears calibration, state and handshakes
module baro_sensor_compensation_core import bsc_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsc_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bsc_out_t            m_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    // calibration registers
    logic [39:0] temp_calib_reg;
    logic [63:0] pres_calib_lo_reg, pres_calib_hi_reg;
    bsc_cmd_t    cmd;
    logic        load, mul_done;
    logic signed [63:0] acc_q, cal_val;
    logic signed [31:0] last_temp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg    <= '0;
            pres_calib_lo_reg <= '0;
            pres_calib_hi_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEMP: temp_calib_reg    <= cfg_data[39:0];
                CFG_PLO:  pres_calib_lo_reg <= cfg_data;
                CFG_PHI:  pres_calib_hi_reg <= cfg_data;
                default:  ; // out-of-range index ignored
            endcase
        end
    end

    // sequencer
    bsc_control #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .temp_cal(temp_calib_reg), .plo(pres_calib_lo_reg), .phi(pres_calib_hi_reg),
        .mul_done, .acc_q, .last_temp, .cmd, .load, .cal_val
    );

    // shared multiply datapath
    bsc_datapath u_dp (
        .aclk, .aresetn, .cmd, .load, .raw_in(s_data.raw_sample), .cal_val, .mul_done,
        .acc_q, .last_temp
    );
endmodule

// File: rtl/core/bsc_checker.sv
// port-level checker for the compensation core, bound to the top level
// depends on bsc_pkg and the defines header
`include "baro_sensor_compensation_core_defines.svh"
module bsc_checker import bsc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input bsc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input bsc_out_t m_data
);
    `BSC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `BSC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BSC_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data))
    `BSC_ASSERT_IMP(a_out_known, aclk, aresetn, m_valid, !$isunknown(m_data))
endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
);

// File: tb/baro_sensor_compensation_core_tb.sv
// testbench for the barometric compensation core: random and directed samples
// checked against an in-bench fixed point predictor; depends on bsc_pkg and the core
`timescale 1ns / 100ps

module baro_sensor_compensation_core_tb;
    import bsc_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;      // settle time, above the pressure latency
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bsc_in_t             s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bsc_out_t            m_data;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    baro_sensor_compensation_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of calibration and the stored temperature
    logic [39:0]        cal_temp = '0;
    logic [63:0]        cal_plo = '0;
    logic [63:0]        cal_phi = '0;
    logic signed [31:0] held_temp = '0;

    bsc_in_t  sample_queue[$];
    bsc_out_t expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    logic     s_taken = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // exact product, floored shift, saturated to 64 bits
    function automatic logic signed [63:0] mul_shift_sat(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
        logic signed [127:0] wa, wb, pr;
        wa = 128'(a);
        wb = 128'(b);
        pr = (wa * wb) >>> sh;
        if (pr[127:63] != {65{pr[127]}})
            return pr[127] ? S64_MIN : S64_MAX;
        return pr[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_bits(input logic signed [63:0] v,
                                                      input int bits);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic logic signed [31:0] temp_model(input logic [23:0] raw);
        logic signed [63:0] t1, t2, t3, d, a, b;
        t1 = {48'd0, cal_temp[15:0]};
        t2 = {48'd0, cal_temp[31:16]};
        t3 = 64'($signed(cal_temp[39:32]));
        d = $signed({40'd0, raw}) - t1 * 256;
        a = mul_shift_sat(d, t2, 30 - FRAC);
        b = mul_shift_sat(d * d, t3, 48 - FRAC);
        return 32'(clamp_bits(add_sat(a, b), 32));
    endfunction

    function automatic logic signed [47:0] pres_model(input logic [23:0] raw);
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic signed [63:0] t, t2, t3, o1, in2, o2, pp, in3, o3, p;
        p1 = 64'($signed(cal_plo[15:0]));
        p2 = 64'($signed(cal_plo[31:16]));
        p3 = 64'($signed(cal_plo[39:32]));
        p4 = 64'($signed(cal_plo[47:40]));
        p5 = {48'd0, cal_plo[63:48]};
        p6 = {48'd0, cal_phi[15:0]};
        p7 = 64'($signed(cal_phi[23:16]));
        p8 = 64'($signed(cal_phi[31:24]));
        p9 = 64'($signed(cal_phi[47:32]));
        p10 = 64'($signed(cal_phi[55:48]));
        p11 = 64'($signed(cal_phi[63:56]));
        p = $signed({40'd0, raw});
        t = 64'(held_temp);
        t2 = mul_shift_sat(t, t, FRAC);
        t3 = mul_shift_sat(t2, t, FRAC);
        o1 = p5 * (64'sd1 <<< (3 + FRAC));
        o1 = add_sat(o1, mul_shift_sat(p6, t, 6));
        o1 = add_sat(o1, mul_shift_sat(p7, t2, 8));
        o1 = add_sat(o1, mul_shift_sat(p8, t3, 15));
        in2 = (p1 - 16384) * (64'sd1 <<< (9 + FRAC));
        in2 = add_sat(in2, mul_shift_sat(p2 - 16384, t, 0));
        in2 = add_sat(in2, mul_shift_sat(p3 * 8, t2, 0));
        in2 = add_sat(in2, mul_shift_sat(p4, t3, 8));
        o2 = mul_shift_sat(p, in2, 29);
        pp = p * p;
        in3 = add_sat(p9 * (64'sd1 <<< FRAC), mul_shift_sat(p10, t, 0));
        o3 = add_sat(mul_shift_sat(pp, in3, 48), mul_shift_sat(pp, p * p11, 65 - FRAC));
        return 48'(clamp_bits(add_sat(add_sat(o1, o2), o3), 48));
    endfunction

    // predict one item's result and advance the stored temperature
    function automatic bsc_out_t predict_sample(input bsc_in_t it);
        bsc_out_t r;
        r.result_kind = it.kind;
        if (it.kind == 1'b0) begin
            held_temp = temp_model(it.raw_sample);
            r.value = it.report_raw ? $signed({24'd0, it.raw_sample}) : 48'(held_temp);
        end else begin
            r.value = it.report_raw ? $signed({24'd0, it.raw_sample})
                                    : pres_model(it.raw_sample);
        end
        return r;
    endfunction

    // monitor: check results first, then record accepted items
    always @(posedge aclk) begin
        bsc_out_t want;
        cycle_count <= cycle_count + 1;
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected item: kind %0d value %0d",
                           m_data.result_kind, m_data.value);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d actual %0d",
                               want.result_kind, m_data.result_kind);
                        error_count++;
                    end
                    if (m_data.value !== want.value) begin
                        $error("value: expected %0d actual %0d", want.value, m_data.value);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_sample(s_data));
        end
    end

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // hold until accepted
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
            s_data <= sample_queue.pop_front();
            s_valid <= 1'b1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: cycles through always-ready, random and mostly-stalled patterns
    always @(negedge aclk) begin
        case ((cycle_count / 331) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("baro_sensor_compensation_core_tb NOT OK");
            $finish;
        end
    end

    // write all three calibration words, optionally a write to the unused index
    task automatic load_calibration(input logic [39:0] tc, input logic [63:0] lo,
                                    input logic [63:0] hi, input bit stray);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= CFG_TEMP; cfg_data <= {24'hA5A5A5, tc};
        cal_temp = tc;
        @(negedge aclk);
        cfg_index <= CFG_PLO; cfg_data <= lo;
        cal_plo = lo;
        @(negedge aclk);
        cfg_index <= CFG_PHI; cfg_data <= hi;
        cal_phi = hi;
        if (stray) begin
            @(negedge aclk);
            cfg_index <= CFG_UNUSED; cfg_data <= {$urandom(), $urandom()};
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until every result is back and the core has gone quiet
    task automatic drain_results();
        while (sample_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic bsc_in_t make_sample(input bit k, input logic [23:0] raw,
                                            input bit rr);
        bsc_in_t it;
        it.kind = k;
        it.raw_sample = raw;
        it.report_raw = rr;
        return it;
    endfunction

    function automatic logic [23:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'({cal_temp[15:0], 8'h00} + $urandom_range(0, 4096) - 2048);
            3: return 24'($urandom_range(0, 255));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        logic [39:0] tc;
        logic [63:0] lo, hi;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // pressure before any temperature, on reset calibration
        sample_queue.push_back(make_sample(1'b1, 24'h6B2F10, 1'b0));
        sample_queue.push_back(make_sample(1'b1, 24'hFFFFFF, 1'b0));
        drain_results();

        // typical calibration, directed corners
        load_calibration({8'hF9, 16'd19000, 16'd27500},
                         {16'd28000, 8'h0A, 8'hF6, 16'hFFD0, 16'hFFF8},
                         {8'hF3, 8'h12, 16'h0800, 8'h9C, 8'h05, 16'd26000}, 1'b1);
        sample_queue.push_back(make_sample(1'b0, 24'h000000, 1'b0));
        sample_queue.push_back(make_sample(1'b0, 24'hFFFFFF, 1'b0));
        sample_queue.push_back(make_sample(1'b0, 24'd7040000, 1'b0));   // d equals zero
        sample_queue.push_back(make_sample(1'b0, 24'h7BC000, 1'b0));
        sample_queue.push_back(make_sample(1'b1, 24'h000000, 1'b0));
        sample_queue.push_back(make_sample(1'b1, 24'hFFFFFF, 1'b0));
        sample_queue.push_back(make_sample(1'b1, 24'h6B2F10, 1'b0));
        sample_queue.push_back(make_sample(1'b1, 24'h6B2F10, 1'b1));    // raw pressure
        sample_queue.push_back(make_sample(1'b0, 24'h800000, 1'b1));    // raw temperature
        sample_queue.push_back(make_sample(1'b1, 24'h6B2F10, 1'b0));    // uses it
        sample_queue.push_back(make_sample(1'b0, 24'hFFFFFF, 1'b1));
        sample_queue.push_back(make_sample(1'b1, 24'hFFFFFF, 1'b1));
        drain_results();

        // random phases, each on its own calibration
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin tc = '1; lo = '1; hi = '1; end
                1: begin tc = '0; lo = '0; hi = '0; end
                2: begin
                    tc = {8'h80, 16'hFFFF, 16'h0000};
                    lo = {16'hFFFF, 8'h80, 8'h80, 16'h8000, 16'h8000};
                    hi = {8'h80, 8'h80, 16'h8000, 8'h80, 8'h80, 16'hFFFF};
                end
                3: begin
                    tc = {8'h7F, 16'hFFFF, 16'hFFFF};
                    lo = {16'hFFFF, 8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF};
                    hi = {8'h7F, 8'h7F, 16'h7FFF, 8'h7F, 8'h7F, 16'hFFFF};
                end
                4: begin
                    tc = {8'hF9, 16'd19000, 16'd27500};
                    lo = {16'd28000, 8'h0A, 8'hF6, 16'hFFD0, 16'hFFF8};
                    hi = {8'hF3, 8'h12, 16'h0800, 8'h9C, 8'h05, 16'd26000};
                end
                default: begin
                    tc = 40'({$urandom(), $urandom()});
                    lo = {$urandom(), $urandom()};
                    hi = {$urandom(), $urandom()};
                end
            endcase
            load_calibration(tc, lo, hi, ph[0]);
            // mostly a temperature followed by a few pressures
            while (sample_queue.size() < 164) begin
                sample_queue.push_back(make_sample(1'b0, pick_raw(),
                                                   $urandom_range(0, 5) == 0));
                repeat ($urandom_range(0, 4))
                    sample_queue.push_back(make_sample($urandom_range(0, 3) != 0,
                                                       pick_raw(),
                                                       $urandom_range(0, 5) == 0));
            end
            drain_results();
        end

        if (error_count == 0)
            $display("baro_sensor_compensation_core_tb OK");
        else
            $display("baro_sensor_compensation_core_tb NOT OK");
        $finish;
    end
endmodule
